@@ rtl/rtoc_pkg.sv @@
// Shared types and constants of the restart type overlap chooser.
package rtoc_pkg;

  typedef enum logic [0:0] {
    CFG_TOP_COUNT   = 1'b0,
    CFG_LIMIT_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic [8:0]  TopCountReset   = 9'd101;
  localparam logic [8:0]  LimitCountReset = 9'd19;
  localparam logic [31:0] HeapLimit       = 32'd10000;
  localparam logic        KindSnapshot    = 1'b0;
  localparam logic        KindDecision    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] var_id;
    logic        last;
    logic [31:0] xor_clause_count;
    logic [31:0] clause_count;
    logic [31:0] heap_size;
  } rtoc_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [8:0]  same_count;
    logic        compared;
    logic        choose_static;
    logic [15:0] rounds;
  } rtoc_out_t;

  typedef struct packed {
    logic cmp_en;
    logic keep;
    logic copy_en;
    logic shift_en;
  } rtoc_cell_ctrl_t;

endpackage

@@ rtl/rtoc_cell.sv @@
// One cell of the id chain: a previous id, a new id and a match bit.
module rtoc_cell import rtoc_pkg::*; #(
  parameter int unsigned MAX_TOP = 256,
  parameter int unsigned IDX     = 0,
  localparam int unsigned LW     = $clog2(MAX_TOP + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rtoc_cell_ctrl_t ctrl_i,
  input  logic [31:0]     var_i,
  input  logic [LW-1:0]   new_len_i,
  input  logic [LW-1:0]   span_i,
  input  logic            hit_i,
  output logic            hit_o
);

  localparam logic [LW-1:0] MyIdx = LW'(IDX);

  logic [31:0] old_q, new_q, new_d;
  logic        hit_q, hit_d;
  logic        wr, match;

  assign wr    = ctrl_i.cmp_en && ctrl_i.keep && (new_len_i == MyIdx);
  assign match = ctrl_i.cmp_en && ctrl_i.keep && (MyIdx < span_i) && !hit_q &&
                 (old_q == var_i);
  assign new_d = wr ? var_i : new_q;
  assign hit_d = ctrl_i.shift_en ? hit_i : (hit_q | match);
  assign hit_o = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    if (ctrl_i.copy_en) begin
      old_q <= new_d;
    end
  end

endmodule

@@ rtl/restart_type_overlap_chooser_core.sv @@
// Snapshot elements without last are accepted back to back, without stalling the input.
// A snapshot end stalls the input through DRAIN and FIN; its result is registered in FIN:
// the match bits shift out of the cell chain one cell per cycle into a counter.
// A choose beat stalls the input: CH1 registers products, CH2 compares, waits if held.
// Reset is asynchronous and clears control, lengths, history and match bits;
// the stored ids are not cleared.
module restart_type_overlap_chooser_core import rtoc_pkg::*; #(
  parameter int unsigned MAX_TOP = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rtoc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rtoc_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned LW = $clog2(MAX_TOP + 1);
  localparam int unsigned IW = $clog2(MAX_TOP);
  localparam int unsigned CW = (LW > 9) ? LW : 9;
  localparam int unsigned SW = 16 + LW;
  localparam int unsigned QW = 16 + 2 * LW;
  localparam int unsigned VW = 32 + 2 * LW;

  typedef enum logic [2:0] {IDLE, DRAIN, FIN, CH1, CH2} state_e;

  state_e          state_q;
  logic [8:0]      top_q, limit_q;
  logic [LW-1:0]   new_len_q, old_len_q, match_q;
  logic [IW-1:0]   cnt_q;
  logic            have_old_q, pend_have_q;
  logic [15:0]     hist_n_q;
  logic [SW-1:0]   hist_s_q;
  logic [QW-1:0]   hist_q_q;
  logic            out_valid_q;
  rtoc_out_t       out_q;

  logic [31:0]     xors_q, clauses_q, heap_q;
  logic [24:0]     ln_q;
  logic [VW-1:0]   nq_q, ss_q;
  logic [31:0]     nn_q;
  logic [35:0]     x10_q;
  logic            heap_lt_q;

  logic            accept, elem, keep, slot_free, rec, decision;
  logic [CW-1:0]   top_ext, eff_ext;
  logic [LW-1:0]   eff_top, span, new_len_inc;
  logic [2*LW-1:0] msq;
  logic [VW-1:0]   s_ext, ln_ext, s10, ln9, nn25;
  logic            t1, t2, var_ok;
  rtoc_cell_ctrl_t cell_ctrl;
  logic [MAX_TOP-1:0] hit;

  assign in_stall_o  = (state_q != IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign elem        = accept && !in_data_i.func;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign top_ext     = CW'(top_q);
  assign eff_ext     = (top_ext > CW'(MAX_TOP)) ? CW'(MAX_TOP) : top_ext;
  assign eff_top     = LW'(eff_ext);
  assign span        = (old_len_q < eff_top) ? old_len_q : eff_top;
  assign keep        = new_len_q < eff_top;
  assign new_len_inc = new_len_q + LW'(keep);

  assign cell_ctrl.cmp_en   = elem;
  assign cell_ctrl.keep     = keep;
  assign cell_ctrl.copy_en  = elem && in_data_i.last;
  assign cell_ctrl.shift_en = (state_q == DRAIN);

  for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
    logic hit_in;
    if (i == MAX_TOP - 1) begin : g_end
      assign hit_in = 1'b0;
    end else begin : g_mid
      assign hit_in = hit[i+1];
    end
    rtoc_cell #(
      .MAX_TOP (MAX_TOP),
      .IDX     (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .var_i     (in_data_i.var_id),
      .new_len_i (new_len_q),
      .span_i    (span),
      .hit_i     (hit_in),
      .hit_o     (hit[i])
    );
  end

  assign rec = pend_have_q && (hist_n_q != 16'hFFFF);
  assign msq = (2*LW)'(match_q) * (2*LW)'(match_q);

  assign s_ext  = VW'(hist_s_q);
  assign ln_ext = VW'(ln_q);
  assign s10    = (s_ext << 3) + (s_ext << 1);
  assign ln9    = (ln_ext << 3) + ln_ext;
  assign nn25   = (VW'(nn_q) << 4) + (VW'(nn_q) << 3) + VW'(nn_q);
  assign t1     = s_ext > ln_ext;
  assign t2     = s10 > ln9;
  assign var_ok = (nq_q < ss_q) || ((nq_q - ss_q) < nn25);
  assign decision = ((hist_n_q != 16'd0) && (t1 || (t2 && var_ok))) ||
                    (x10_q > 36'(clauses_q)) || heap_lt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= TopCountReset;
      limit_q <= LimitCountReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TOP_COUNT) begin
        top_q <= cfg_data_i;
      end else begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.func) begin
      xors_q    <= in_data_i.xor_clause_count;
      clauses_q <= in_data_i.clause_count;
      heap_q    <= in_data_i.heap_size;
    end
    if (state_q == CH1) begin
      ln_q      <= 25'(limit_q) * 25'(hist_n_q);
      nq_q      <= VW'(hist_n_q) * VW'(hist_q_q);
      ss_q      <= VW'(hist_s_q) * VW'(hist_s_q);
      nn_q      <= 32'(hist_n_q) * 32'(hist_n_q);
      x10_q     <= (36'(xors_q) << 3) + (36'(xors_q) << 1);
      heap_lt_q <= heap_q < HeapLimit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      new_len_q   <= '0;
      old_len_q   <= '0;
      match_q     <= '0;
      cnt_q       <= '0;
      have_old_q  <= 1'b0;
      pend_have_q <= 1'b0;
      hist_n_q    <= '0;
      hist_s_q    <= '0;
      hist_q_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (accept) begin
            if (in_data_i.func) begin
              state_q <= CH1;
            end else if (in_data_i.last) begin
              old_len_q   <= new_len_inc;
              have_old_q  <= (new_len_inc != '0);
              pend_have_q <= have_old_q;
              new_len_q   <= '0;
              match_q     <= '0;
              cnt_q       <= '0;
              state_q     <= DRAIN;
            end else begin
              new_len_q <= new_len_inc;
            end
          end
        end
        DRAIN: begin
          match_q <= match_q + LW'(hit[0]);
          cnt_q   <= cnt_q + IW'(1);
          if (cnt_q == IW'(MAX_TOP - 1)) begin
            state_q <= FIN;
          end
        end
        FIN: begin
          if (slot_free) begin
            if (rec) begin
              hist_n_q <= hist_n_q + 16'd1;
              hist_s_q <= hist_s_q + SW'(match_q);
              hist_q_q <= hist_q_q + QW'(msq);
            end
            out_q.result_kind   <= KindSnapshot;
            out_q.same_count    <= 9'(match_q);
            out_q.compared      <= rec;
            out_q.choose_static <= 1'b0;
            out_q.rounds        <= rec ? (hist_n_q + 16'd1) : hist_n_q;
            out_valid_q         <= 1'b1;
            match_q             <= '0;
            state_q             <= IDLE;
          end
        end
        CH1: begin
          state_q <= CH2;
        end
        CH2: begin
          if (slot_free) begin
            out_q.result_kind   <= KindDecision;
            out_q.same_count    <= 9'd0;
            out_q.compared      <= 1'b0;
            out_q.choose_static <= decision;
            out_q.rounds        <= hist_n_q;
            out_valid_q         <= 1'b1;
            state_q             <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the restart type overlap chooser core.
module testbench;
  import rtoc_pkg::*;

  localparam int unsigned MAX_TOP     = 256;
  localparam int unsigned ITEMS       = 1550;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam logic        FuncSnapshot = 1'b0;
  localparam logic        FuncChoose   = 1'b1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  rtoc_in_t   in_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rtoc_out_t  out_data;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_idx = CFG_TOP_COUNT;
  logic [8:0] cfg_data = '0;

  restart_type_overlap_chooser_core #(
    .MAX_TOP(MAX_TOP)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rtoc_in_t    pending_beats [$];
  rtoc_out_t   expected_outcomes [$];
  int unsigned stim_count = 0;
  int unsigned mismatches = 0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int unsigned hold_requests = 0;
  logic [31:0] gen_prev [$];

  // Shadow of the block: configuration, snapshot lists and overlap history.
  logic [8:0]      top_cfg = TopCountReset;
  logic [8:0]      limit_cfg = LimitCountReset;
  logic [31:0]     prev_ids [MAX_TOP];
  logic [31:0]     cur_ids [MAX_TOP];
  bit              prev_hit [MAX_TOP];
  int unsigned     prev_len = 0;
  int unsigned     cur_len = 0;
  bit              prev_valid = 1'b0;
  longint unsigned overlap_acc = 0;
  longint unsigned overlap_sum = 0;
  longint unsigned overlap_sumsq = 0;
  int unsigned     rounds_n = 0;

  function automatic int unsigned eff_top();
    return (top_cfg > MAX_TOP) ? MAX_TOP : 32'(top_cfg);
  endfunction

  function automatic bit static_restarts_wanted(rtoc_in_t b);
    longint unsigned n, l, nq, ss, xors, clauses;
    bit res;
    n = 64'(rounds_n);
    l = 64'(limit_cfg);
    xors = 64'(b.xor_clause_count);
    clauses = 64'(b.clause_count);
    res = 1'b0;
    if (n != 0) begin
      if (overlap_sum > l * n) res = 1'b1;
      if (10 * overlap_sum > 9 * l * n) begin
        nq = n * overlap_sumsq;
        ss = overlap_sum * overlap_sum;
        if (nq < ss || nq - ss < 25 * n * n) res = 1'b1;
      end
    end
    if (10 * xors > clauses) res = 1'b1;
    if (b.heap_size < HeapLimit) res = 1'b1;
    return res;
  endfunction

  task automatic predict_overlap(rtoc_in_t b);
    rtoc_out_t   r;
    int unsigned top, span;
    r = '0;
    if (b.func == FuncChoose) begin
      r.result_kind = KindDecision;
      r.choose_static = static_restarts_wanted(b);
      r.rounds = 16'(rounds_n);
      expected_outcomes.insert(expected_outcomes.size(), r);
    end else begin
      top = eff_top();
      if (cur_len < top) begin
        cur_ids[cur_len] = b.var_id;
        cur_len++;
        span = (prev_len < top) ? prev_len : top;
        for (int unsigned i = 0; i < span; i++) begin
          if (!prev_hit[i] && prev_ids[i] == b.var_id) begin
            prev_hit[i] = 1'b1;
            overlap_acc++;
          end
        end
      end
      if (b.last) begin
        r.result_kind = KindSnapshot;
        r.same_count = 9'(overlap_acc);
        if (prev_valid && rounds_n < 32'hFFFF) begin
          rounds_n++;
          overlap_sum += overlap_acc;
          overlap_sumsq += overlap_acc * overlap_acc;
          r.compared = 1'b1;
        end
        r.rounds = 16'(rounds_n);
        expected_outcomes.insert(expected_outcomes.size(), r);
        prev_ids = cur_ids;
        prev_len = cur_len;
        prev_valid = (cur_len != 0);
        cur_len = 0;
        overlap_acc = 0;
        foreach (prev_hit[i]) prev_hit[i] = 1'b0;
      end
    end
  endtask

  // Sender side: offers queued beats with random gaps and predicts each accepted one.
  int unsigned src_gap = 0;

  always @(posedge clk) begin : drive_in
    logic nxt_valid;
    logic took;
    if (rst_n) begin
      took = in_valid && !in_stall;
      if (took) predict_overlap(in_data);
      if (!in_valid || took) begin
        nxt_valid = 1'b0;
        if (src_gap != 0) begin
          src_gap--;
        end else if (src_idle_en && pending_beats.size() != 0 && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(1, 15) - 1;
        end else if (pending_beats.size() != 0) begin
          in_data <= pending_beats.pop_front();
          nxt_valid = 1'b1;
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // Receiver side: random stall bursts plus long hold-offs on request.
  int unsigned snk_gap = 0;
  int unsigned hold_left = 0;
  int unsigned holds_served = 0;

  always @(posedge clk) begin : drive_stall
    logic nxt_stall;
    nxt_stall = 1'b1;
    if (hold_left != 0) begin
      hold_left--;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
    end else if (snk_gap != 0) begin
      snk_gap--;
    end else if (snk_idle_en && $urandom_range(0, 11) == 0) begin
      snk_gap = $urandom_range(1, 15) - 1;
    end else begin
      nxt_stall = 1'b0;
    end
    out_stall <= nxt_stall;
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_out
    rtoc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("result_kind", 16'(want.result_kind), 16'(out_data.result_kind));
        check_field("same_count", 16'(want.same_count), 16'(out_data.same_count));
        check_field("compared", 16'(want.compared), 16'(out_data.compared));
        check_field("choose_static", 16'(want.choose_static), 16'(out_data.choose_static));
        check_field("rounds", want.rounds, out_data.rounds);
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic rtoc_in_t snap_beat(logic [31:0] id, logic last);
    rtoc_in_t b;
    b = '0;
    b.func = FuncSnapshot;
    b.var_id = id;
    b.last = last;
    return b;
  endfunction

  function automatic rtoc_in_t choose_beat(logic [31:0] xors, logic [31:0] clauses,
                                           logic [31:0] heap);
    rtoc_in_t b;
    b = '0;
    b.func = FuncChoose;
    b.xor_clause_count = xors;
    b.clause_count = clauses;
    b.heap_size = heap;
    return b;
  endfunction

  function automatic logic [31:0] pick_id(int unsigned reuse_pct);
    if (gen_prev.size() != 0 && $urandom_range(0, 99) < reuse_pct)
      return gen_prev[$urandom_range(0, gen_prev.size() - 1)];
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 63);
  endfunction

  task automatic push_beat(rtoc_in_t b, bit counts);
    pending_beats.insert(pending_beats.size(), b);
    if (counts) stim_count++;
  endtask

  task automatic add_choose();
    rtoc_in_t    b;
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 5))
      0: b = choose_beat($urandom, $urandom, $urandom);
      1: b = choose_beat($urandom, $urandom, $urandom_range(0, 9999));
      2: b = choose_beat(c / 10 + $urandom_range(0, 1), c, $urandom_range(10000, 32'hFFFFFFFF));
      default: b = choose_beat('0, c, $urandom_range(10000, 32'hFFFFFFFF));
    endcase
    b.var_id = $urandom;
    b.last = 1'($urandom);
    push_beat(b, 1'b1);
  endtask

  task automatic add_snapshot(int unsigned len, int unsigned reuse_pct, bit mixed, bit close);
    logic [31:0] ids [$];
    rtoc_in_t    b;
    for (int unsigned k = 0; k < len; k++) begin
      b = snap_beat(pick_id(reuse_pct), close && k == len - 1);
      b.xor_clause_count = $urandom;
      b.clause_count = $urandom;
      b.heap_size = $urandom;
      push_beat(b, k < eff_top());
      ids.insert(ids.size(), b.var_id);
      if (mixed && !b.last && $urandom_range(0, 29) == 0) add_choose();
    end
    if (close) gen_prev = ids;
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOP_COUNT) top_cfg = val;
    else limit_cfg = val;
  endtask

  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (MAX_TOP + 16) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase, big_stage, n_snap, len, reuse;
    logic [8:0]  top_v, lim_v;
    bit          full;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_beat(choose_beat('0, '0, '0), 1'b1);
    push_beat(choose_beat('0, '0, 32'd10000), 1'b1);
    push_beat(choose_beat('0, '0, 32'd9999), 1'b1);
    push_beat(choose_beat(32'd1, 32'd10, '1), 1'b1);
    push_beat(choose_beat(32'd1, 32'd9, '1), 1'b1);
    push_beat(choose_beat('1, '1, '1), 1'b1);
    push_beat(snap_beat('0, 1'b0), 1'b1);
    push_beat(snap_beat('1, 1'b0), 1'b1);
    push_beat(snap_beat(32'd5, 1'b1), 1'b1);
    push_beat(snap_beat('1, 1'b0), 1'b1);
    push_beat(snap_beat('0, 1'b0), 1'b1);
    push_beat(snap_beat('0, 1'b0), 1'b1);
    push_beat(snap_beat(32'd7, 1'b1), 1'b1);
    push_beat(snap_beat(32'd5, 1'b0), 1'b1);
    push_beat(choose_beat('0, '1, '1), 1'b1);
    push_beat(snap_beat(32'd5, 1'b1), 1'b1);
    push_beat(choose_beat('0, '1, '1), 1'b1);
    push_beat(snap_beat(32'd9, 1'b1), 1'b1);
    settle();

    phase = 0;
    big_stage = 0;
    while (stim_count < ITEMS) begin
      full = 1'b0;
      reuse = $urandom_range(40, 100);
      if (phase == 0) begin
        top_v = '0;
        lim_v = '0;
      end else if (phase == 1) begin
        top_v = 9'd1;
        lim_v = 9'd1;
      end else if (phase < 10) begin
        top_v = 9'($urandom_range(8, 12));
        lim_v = 9'($urandom_range(4, 14));
        reuse = $urandom_range(85, 100);
      end else if (big_stage < 3 && stim_count >= ITEMS / 2) begin
        top_v = (big_stage == 0) ? 9'd256 : (big_stage == 1) ? 9'd511 : 9'd257;
        lim_v = (big_stage == 0) ? 9'd511 : (big_stage == 1) ? 9'd256 : 9'd19;
        full = (big_stage != 2);
        big_stage++;
      end else begin
        top_v = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                             : 9'($urandom_range(1, 32));
        lim_v = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                             : 9'($urandom_range(0, 24));
      end
      write_cfg(CFG_TOP_COUNT, top_v);
      write_cfg(CFG_LIMIT_COUNT, lim_v);
      if (stim_count > ITEMS * 85 / 100) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end else begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
      end
      @(negedge clk);
      if (phase == 3) begin
        hold_requests++;
        repeat (40) add_choose();
      end
      n_snap = full ? 1 : $urandom_range(3, 10);
      for (int unsigned s = 0; s < n_snap; s++) begin
        repeat ($urandom_range(0, 2)) add_choose();
        if (full) len = eff_top() + $urandom_range(1, 3);
        else if (eff_top() == 0) len = $urandom_range(1, 3);
        else if (eff_top() > 40) len = $urandom_range(1, 40);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, eff_top() + 2);
        else len = eff_top() + $urandom_range(0, 2);
        add_snapshot(len, reuse, !full, s != n_snap - 1 || $urandom_range(0, 7) != 0);
      end
      add_choose();
      settle();
      phase++;
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
